// ===== design/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg - shared types and codes of the bounded deque engine
// Holds the command and status codes, the chain actions, the per-slot
// operations and the control bundle that the top level hands to the chain.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // command codes of the input word
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // status codes of the result word
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // what the whole row of slots does in one cycle
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_POP_FRONT,
    ACT_ROTATE
  } chain_act_t;

  // what a single slot does in one cycle
  typedef enum logic [2:0] {
    SLOT_HOLD,
    SLOT_LOAD,
    SLOT_FROM_PREV,
    SLOT_FROM_NEXT,
    SLOT_FROM_HEAD
  } slot_op_t;

  // control bundle from the sequencer to the chain
  typedef struct packed {
    chain_act_t        action;
    logic [WORD_W-1:0] push_word;
  } chain_ctrl_t;

endpackage

// ===== design/bde_ifs.sv =====
// ----------------------------------------------------------------------------
// bde_ifs - channel interfaces of the bounded deque engine
// Command channel and result channel, each a valid/ready pair with payload.
// ----------------------------------------------------------------------------
interface bde_in_if
  import bde_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface bde_out_if
  import bde_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word_out;
  logic [STATUS_W-1:0]      status;
  logic                     last_of_run;

  modport source (output valid, output word_out, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input word_out, input status, input last_of_run,
                  output ready);
endinterface

// ===== design/bounded_deque_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit - bounded double-ended queue of signed words
// Use: commands arrive on in_ch (cmd, push_value), results leave on out_ch
// (word_out, status, last_of_run); both are valid/ready channels and a word
// moves at a clock edge where valid and ready are both high.
// Push front/back, pop front/back: one result word, registered, valid the
// cycle after the command is taken; a new command is taken every cycle while
// the output register is empty or being drained, so one command per cycle.
// Dump of n stored words: n result words, one per cycle while out_ch is
// ready, the first one passing through dumping_r and then the output
// register, the last one flagged by last_of_run; a dump of an empty queue
// gives one word with status empty the cycle after. During a dump no
// command is taken, and the slot chain rotates one place per result.
// Codes 5 to 7 are dropped with no result.
// Reset (rst_n low, synchronous) empties the queue and the output register;
// slot contents are not cleared. When out_ch stalls, the held result stays
// and in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module bounded_deque_engine_unit
  import bde_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bde_in_if.sink     in_ch,
  bde_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              dumping_r, dumping_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [STATUS_W-1:0] out_status_r;
  logic              out_last_r;

  logic              out_free;
  logic              in_accept;
  logic              res_load;
  logic [WORD_W-1:0] res_word;
  logic [STATUS_W-1:0] res_status;
  logic              res_last;
  chain_ctrl_t       ctrl;
  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] back_word;
  logic              is_full;
  logic              is_empty;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !dumping_r && out_free;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(CAPACITY));
  assign is_empty    = (count_r == '0);

  // slot chain
  bde_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .count     (count_r),
    .head_word (head_word),
    .back_word (back_word)
  );

  // command decode and dump sequencing
  always_comb begin
    ctrl.action    = ACT_NONE;
    ctrl.push_word = in_ch.push_value;
    res_load       = 1'b0;
    res_word       = '0;
    res_status     = ST_OK;
    res_last       = 1'b1;
    count_nxt      = count_r;
    dumping_nxt    = dumping_r;
    left_nxt       = left_r;
    if (dumping_r) begin
      if (out_free) begin
        res_load    = 1'b1;
        res_word    = head_word;
        res_last    = (left_r == CNT_W'(1));
        ctrl.action = ACT_ROTATE;
        left_nxt    = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) begin
          dumping_nxt = 1'b0;
        end
      end
    end else if (in_accept) begin
      unique case (in_ch.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          res_load = 1'b1;
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            ctrl.action = (in_ch.cmd == CMD_PUSH_FRONT) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          res_load = 1'b1;
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_word    = head_word;
            ctrl.action = ACT_POP_FRONT;
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          res_load = 1'b1;
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_word  = back_word;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_DUMP: begin
          if (is_empty) begin
            res_load   = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            dumping_nxt = 1'b1;
            left_nxt    = count_r;
          end
        end
        default: begin
          res_load = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_r      <= '0;
      dumping_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      left_r    <= left_nxt;
      dumping_r <= dumping_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.word_out    = out_word_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> !in_ch.ready)
    else $error("command taken during dump");

  a_dump_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> (left_r != '0))
    else $error("dump running with nothing left");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |=> (count_r == $past(count_r)))
    else $error("entry count changed during dump");

endmodule

// ===== design/bde_cell.sv =====
// ----------------------------------------------------------------------------
// bde_cell - one storage slot of the deque chain
// Holds one word and takes it from its left or right neighbor, from the
// head slot, from the push word, or keeps it, as the chain tells it.
// ----------------------------------------------------------------------------
module bde_cell
  import bde_pkg::*;
(
  input  logic              clk,
  input  slot_op_t          op,
  input  logic [WORD_W-1:0] push_word,
  input  logic [WORD_W-1:0] prev_word,
  input  logic [WORD_W-1:0] next_word,
  input  logic [WORD_W-1:0] head_word,
  output logic [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // slot input select
  always_comb begin
    unique case (op)
      SLOT_LOAD:      word_nxt = push_word;
      SLOT_FROM_PREV: word_nxt = prev_word;
      SLOT_FROM_NEXT: word_nxt = next_word;
      SLOT_FROM_HEAD: word_nxt = head_word;
      default:        word_nxt = word_r;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== design/bde_chain.sv =====
// ----------------------------------------------------------------------------
// bde_chain - row of deque slots, front at slot 0
// Words are packed from slot 0 (front) to slot count-1 (back). Push front
// and pop front shift the row, push back loads one slot, a dump step
// rotates the occupied slots by one so the front word circles to the back.
// ----------------------------------------------------------------------------
module bde_chain
  import bde_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  chain_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]  count,
  output logic [WORD_W-1:0] head_word,
  output logic [WORD_W-1:0] back_word
);

  logic [WORD_W-1:0] slot_word [CAPACITY];
  slot_op_t          slot_ops  [CAPACITY];
  logic [CNT_W-1:0]  cnt_m1;

  assign cnt_m1    = count - CNT_W'(1);
  assign head_word = slot_word[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic [WORD_W-1:0] prev_w;
    logic [WORD_W-1:0] next_w;

    // neighbor wiring, the ends see the push word and themselves
    if (i == 0) begin : g_first
      assign prev_w = ctrl.push_word;
    end else begin : g_prev
      assign prev_w = slot_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = slot_word[i];
    end else begin : g_next
      assign next_w = slot_word[i+1];
    end

    // per-slot operation from the chain action
    always_comb begin
      unique case (ctrl.action)
        ACT_PUSH_FRONT: slot_ops[i] = SLOT_FROM_PREV;
        ACT_PUSH_BACK:
          slot_ops[i] = (CNT_W'(i) == count) ? SLOT_LOAD : SLOT_HOLD;
        ACT_POP_FRONT:  slot_ops[i] = SLOT_FROM_NEXT;
        ACT_ROTATE: begin
          if (CNT_W'(i) < cnt_m1) begin
            slot_ops[i] = SLOT_FROM_NEXT;
          end else if (CNT_W'(i) == cnt_m1) begin
            slot_ops[i] = SLOT_FROM_HEAD;
          end else begin
            slot_ops[i] = SLOT_HOLD;
          end
        end
        default:        slot_ops[i] = SLOT_HOLD;
      endcase
    end

    bde_cell u_slot (
      .clk       (clk),
      .op        (slot_ops[i]),
      .push_word (ctrl.push_word),
      .prev_word (prev_w),
      .next_word (next_w),
      .head_word (slot_word[0]),
      .word      (slot_word[i])
    );
  end

  // back word: and-or select over the slot that sits at count-1
  always_comb begin
    back_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_word = back_word | ({WORD_W{CNT_W'(i) == cnt_m1}} & slot_word[i]);
    end
  end

endmodule
